>>> rtl/rgb_box_blur_window_mean_unit_defines.svh
// ----------------------------------------------------------------------------
// rgb box blur window mean unit - assertion macros
// Shared concurrent assertion forms for the blur unit
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_WINDOW_MEAN_UNIT_DEFINES_SVH
`define RGB_BOX_BLUR_WINDOW_MEAN_UNIT_DEFINES_SVH

// condition that must hold on every clock edge out of reset
`define RBBWM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define RBBWM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/rbbwm_pkg.sv
// ----------------------------------------------------------------------------
// rbbwm_pkg
// Types, sizes and codes shared by the box blur window mean unit
// ----------------------------------------------------------------------------
package rbbwm_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MAX_RADIUS = 7;

	localparam int X_W      = 7;
	localparam int Y_W      = 7;
	localparam int DIM_W    = 8;
	localparam int RADIUS_W = 3;
	localparam int COLOUR_W = 8;
	localparam int PIX_W    = 3 * COLOUR_W;
	localparam int LANES    = 3;
	localparam int COUNT_OUT_W = 8;

	localparam int ADDR_W = X_W + Y_W;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

	localparam int MAX_CNT = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int CNT_W   = $clog2(MAX_CNT + 1);
	localparam int SUM_W   = COLOUR_W + CNT_W;
	localparam int STEP_W  = $clog2(SUM_W + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);
	localparam logic [DIM_W-1:0]    WIDTH_RST  = DIM_W'(128);
	localparam logic [DIM_W-1:0]    HEIGHT_RST = DIM_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_RADIUS = 2'd0,
		CFG_IMAGE_WIDTH   = 2'd1,
		CFG_IMAGE_HEIGHT  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV
	} blk_state_t;

	typedef logic [LANES-1:0][SUM_W-1:0]    sum_vec_t;
	typedef logic [LANES-1:0][COLOUR_W-1:0] mean_vec_t;

endpackage

>>> rtl/rbbwm_if.sv
// ----------------------------------------------------------------------------
// rbbwm interfaces
// Valid/ready channels for pixel items, blur results and register writes
// ----------------------------------------------------------------------------
interface rbbwm_item_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [rbbwm_pkg::X_W-1:0]      pos_x;
	logic [rbbwm_pkg::Y_W-1:0]      pos_y;
	logic [rbbwm_pkg::COLOUR_W-1:0] in_red;
	logic [rbbwm_pkg::COLOUR_W-1:0] in_green;
	logic [rbbwm_pkg::COLOUR_W-1:0] in_blue;

	modport source (output valid, kind, pos_x, pos_y, in_red, in_green, in_blue,
		input ready);
	modport sink (input valid, kind, pos_x, pos_y, in_red, in_green, in_blue,
		output ready);
endinterface

interface rbbwm_result_if;
	logic                             valid;
	logic                             ready;
	logic [rbbwm_pkg::X_W-1:0]         out_x;
	logic [rbbwm_pkg::Y_W-1:0]         out_y;
	logic [rbbwm_pkg::COLOUR_W-1:0]    mean_red;
	logic [rbbwm_pkg::COLOUR_W-1:0]    mean_green;
	logic [rbbwm_pkg::COLOUR_W-1:0]    mean_blue;
	logic [rbbwm_pkg::COUNT_OUT_W-1:0] pixel_count;

	modport source (output valid, out_x, out_y, mean_red, mean_green, mean_blue,
		pixel_count, input ready);
	modport sink (input valid, out_x, out_y, mean_red, mean_green, mean_blue,
		pixel_count, output ready);
endinterface

interface rbbwm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rbbwm_pkg::CFG_IDX_W-1:0]  index;
	logic [rbbwm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rbbwm_ram.sv
// ----------------------------------------------------------------------------
// rbbwm_ram
// Generic single-port synchronous RAM with registered read data
// ----------------------------------------------------------------------------
module rbbwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/rbbwm_div.sv
// ----------------------------------------------------------------------------
// rbbwm_div
// Three-lane restoring divider, one quotient bit per lane per cycle
// ----------------------------------------------------------------------------
module rbbwm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  rbbwm_pkg::sum_vec_t         dividend,
	input  logic [rbbwm_pkg::CNT_W-1:0] divisor,
	output logic                        busy,
	output rbbwm_pkg::mean_vec_t        quotient
);

	logic [rbbwm_pkg::STEP_W-1:0]                     step_q;
	logic [rbbwm_pkg::CNT_W-1:0]                      div_q;
	rbbwm_pkg::sum_vec_t                              quo_q;
	logic [rbbwm_pkg::LANES-1:0][rbbwm_pkg::CNT_W-1:0] rem_q;
	rbbwm_pkg::sum_vec_t                              quo_d;
	logic [rbbwm_pkg::LANES-1:0][rbbwm_pkg::CNT_W-1:0] rem_d;

	assign busy = (step_q != '0);

	// shift in the next dividend bit and subtract where the remainder allows
	always_comb begin
		logic [rbbwm_pkg::CNT_W:0] shifted;
		logic                      ge;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int l = 0; l < rbbwm_pkg::LANES; l++) begin
			shifted  = {rem_q[l], quo_q[l][rbbwm_pkg::SUM_W-1]};
			ge       = (shifted >= {1'b0, div_q});
			rem_d[l] = ge ? rbbwm_pkg::CNT_W'(shifted - {1'b0, div_q})
				: shifted[rbbwm_pkg::CNT_W-1:0];
			quo_d[l] = {quo_q[l][rbbwm_pkg::SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= rbbwm_pkg::STEP_W'(rbbwm_pkg::SUM_W);
		end else if (busy) begin
			step_q <= step_q - rbbwm_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	always_comb begin
		for (int l = 0; l < rbbwm_pkg::LANES; l++) begin
			quotient[l] = quo_q[l][rbbwm_pkg::COLOUR_W-1:0];
		end
	end

endmodule

>>> rtl/rgb_box_blur_window_mean_unit.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_window_mean_unit
// RGB frame store with per-channel box blur queries over a clipped window
// ----------------------------------------------------------------------------
// A write word stores one pixel. A query word walks the clipped window
// through the single frame store port, one pixel per cycle, then runs a
// three-lane divider that yields one quotient bit per cycle (a window
// holds at most 225 pixels at radius 7). Only the idle sequencer accepts
// a word; a finished result waits in the output register while the next
// word is taken. The frame store has no reset, so pixels must be written
// before a query covers them.
`include "rgb_box_blur_window_mean_unit_defines.svh"

module rgb_box_blur_window_mean_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	rbbwm_item_if.sink            item,
	rbbwm_result_if.source        result,
	rbbwm_cfg_if.sink             cfg
);

	// configuration
	logic [rbbwm_pkg::RADIUS_W-1:0] radius_q;
	logic [rbbwm_pkg::DIM_W-1:0]    width_q;
	logic [rbbwm_pkg::DIM_W-1:0]    height_q;

	logic [rbbwm_pkg::DIM_W-1:0]    w_eff;
	logic [rbbwm_pkg::DIM_W-1:0]    h_eff;
	logic [rbbwm_pkg::DIM_W-1:0]    r_eff;

	// window walk
	rbbwm_pkg::blk_state_t          state_q, state_d;
	logic [rbbwm_pkg::X_W-1:0]      col_q, c0_q, c1_q, qx_q;
	logic [rbbwm_pkg::Y_W-1:0]      row_q, r1_q, qy_q;
	logic                           rd_vld_s1;
	rbbwm_pkg::sum_vec_t            sum_q;
	logic [rbbwm_pkg::CNT_W-1:0]    cnt_q;

	logic [rbbwm_pkg::DIM_W-1:0]    xe, ye;
	logic [rbbwm_pkg::DIM_W-1:0]    c0_w, c1_w, r0_w, r1_w;
	logic                           in_range;
	logic                           item_acc;
	logic                           last_rd;

	// frame store
	logic                           ram_we;
	logic [rbbwm_pkg::ADDR_W-1:0]   ram_addr;
	logic [rbbwm_pkg::PIX_W-1:0]    ram_wdata;
	logic [rbbwm_pkg::PIX_W-1:0]    ram_rdata;

	// divider and output
	logic                           div_start;
	logic                           div_busy;
	rbbwm_pkg::mean_vec_t           div_quo;
	logic                           out_load;
	logic                           out_vld_q;
	logic [rbbwm_pkg::X_W-1:0]      out_x_q;
	logic [rbbwm_pkg::Y_W-1:0]      out_y_q;
	rbbwm_pkg::mean_vec_t           mean_q;
	logic [rbbwm_pkg::COUNT_OUT_W-1:0] count_q;

	// ---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= rbbwm_pkg::RADIUS_RST;
			width_q  <= rbbwm_pkg::WIDTH_RST;
			height_q <= rbbwm_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rbbwm_pkg::CFG_WINDOW_RADIUS: begin
					radius_q <= cfg.data[rbbwm_pkg::RADIUS_W-1:0];
				end
				rbbwm_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= cfg.data[rbbwm_pkg::DIM_W-1:0];
				end
				rbbwm_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= cfg.data[rbbwm_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero acts as one, oversize acts as the frame limit
	always_comb begin
		if (width_q == '0) begin
			w_eff = rbbwm_pkg::DIM_W'(1);
		end else if (width_q > rbbwm_pkg::DIM_W'(rbbwm_pkg::MAX_WIDTH)) begin
			w_eff = rbbwm_pkg::DIM_W'(rbbwm_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = rbbwm_pkg::DIM_W'(1);
		end else if (height_q > rbbwm_pkg::DIM_W'(rbbwm_pkg::MAX_HEIGHT)) begin
			h_eff = rbbwm_pkg::DIM_W'(rbbwm_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		if ({1'b0, radius_q} > (rbbwm_pkg::RADIUS_W + 1)'(rbbwm_pkg::MAX_RADIUS)) begin
			r_eff = rbbwm_pkg::DIM_W'(rbbwm_pkg::MAX_RADIUS);
		end else begin
			r_eff = rbbwm_pkg::DIM_W'(radius_q);
		end
	end

	// ---------------------------------------------------------------- window bounds
	assign xe       = rbbwm_pkg::DIM_W'(item.pos_x);
	assign ye       = rbbwm_pkg::DIM_W'(item.pos_y);
	assign in_range = (xe < w_eff) && (ye < h_eff);
	assign item_acc = item.valid && item.ready;

	assign c0_w = (xe > r_eff) ? xe - r_eff : '0;
	assign r0_w = (ye > r_eff) ? ye - r_eff : '0;
	assign c1_w = (xe + r_eff < w_eff) ? xe + r_eff : w_eff - rbbwm_pkg::DIM_W'(1);
	assign r1_w = (ye + r_eff < h_eff) ? ye + r_eff : h_eff - rbbwm_pkg::DIM_W'(1);

	assign last_rd = (col_q == c1_q) && (row_q == r1_q);

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbbwm_pkg::ST_IDLE: begin
				if (item_acc && in_range && (item.kind == rbbwm_pkg::KIND_QUERY)) begin
					state_d = rbbwm_pkg::ST_SCAN;
				end
			end
			rbbwm_pkg::ST_SCAN: begin
				if (last_rd) begin
					state_d = rbbwm_pkg::ST_DRAIN;
				end
			end
			rbbwm_pkg::ST_DRAIN: begin
				state_d = rbbwm_pkg::ST_DIV_START;
			end
			rbbwm_pkg::ST_DIV_START: begin
				state_d = rbbwm_pkg::ST_DIV;
			end
			rbbwm_pkg::ST_DIV: begin
				if (out_load) begin
					state_d = rbbwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rbbwm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item.ready = (state_q == rbbwm_pkg::ST_IDLE);
		ram_we     = (state_q == rbbwm_pkg::ST_IDLE) && item_acc && in_range
			&& (item.kind == rbbwm_pkg::KIND_WRITE);
		ram_addr   = (state_q == rbbwm_pkg::ST_IDLE) ? {item.pos_y, item.pos_x}
			: {row_q, col_q};
		div_start  = (state_q == rbbwm_pkg::ST_DIV_START);
		out_load   = (state_q == rbbwm_pkg::ST_DIV) && !div_busy
			&& (!out_vld_q || result.ready);
	end

	assign ram_wdata = {item.in_red, item.in_green, item.in_blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rbbwm_pkg::ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == rbbwm_pkg::ST_SCAN);
		end
	end

	// row-major walk over the clipped window, rows outer
	always_ff @(posedge clk) begin
		if (state_q == rbbwm_pkg::ST_IDLE && item_acc) begin
			col_q <= c0_w[rbbwm_pkg::X_W-1:0];
			c0_q  <= c0_w[rbbwm_pkg::X_W-1:0];
			c1_q  <= c1_w[rbbwm_pkg::X_W-1:0];
			row_q <= r0_w[rbbwm_pkg::Y_W-1:0];
			r1_q  <= r1_w[rbbwm_pkg::Y_W-1:0];
			qx_q  <= item.pos_x;
			qy_q  <= item.pos_y;
		end else if (state_q == rbbwm_pkg::ST_SCAN) begin
			if (col_q == c1_q) begin
				col_q <= c0_q;
				row_q <= row_q + rbbwm_pkg::Y_W'(1);
			end else begin
				col_q <= col_q + rbbwm_pkg::X_W'(1);
			end
		end
	end

	// accumulate read data in the cycle after its address is presented
	always_ff @(posedge clk) begin
		if (state_q == rbbwm_pkg::ST_IDLE && item_acc) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (rd_vld_s1) begin
			for (int l = 0; l < rbbwm_pkg::LANES; l++) begin
				sum_q[l] <= sum_q[l] + rbbwm_pkg::SUM_W'(
					ram_rdata[(rbbwm_pkg::LANES-1-l)*rbbwm_pkg::COLOUR_W +:
						rbbwm_pkg::COLOUR_W]);
			end
			cnt_q <= cnt_q + rbbwm_pkg::CNT_W'(1);
		end
	end

	// ---------------------------------------------------------------- units
	rbbwm_ram #(
		.WIDTH (rbbwm_pkg::PIX_W),
		.DEPTH (rbbwm_pkg::DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	rbbwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= qx_q;
			out_y_q <= qy_q;
			mean_q  <= div_quo;
			count_q <= rbbwm_pkg::COUNT_OUT_W'(cnt_q);
		end
	end

	assign result.valid       = out_vld_q;
	assign result.out_x       = out_x_q;
	assign result.out_y       = out_y_q;
	assign result.mean_red    = mean_q[0];
	assign result.mean_green  = mean_q[1];
	assign result.mean_blue   = mean_q[2];
	assign result.pixel_count = count_q;

	// ---------------------------------------------------------------- checks
	`RBBWM_ASSERT(a_we_idle, clk, arst_n, !ram_we || (state_q == rbbwm_pkg::ST_IDLE), "frame write outside idle")
	`RBBWM_ASSERT(a_rd_window, clk, arst_n, !rd_vld_s1 || (state_q == rbbwm_pkg::ST_SCAN) || (state_q == rbbwm_pkg::ST_DRAIN), "read data arrived outside the walk")
	`RBBWM_ASSERT(a_div_free, clk, arst_n, !div_start || !div_busy, "divider restarted while busy")
	`RBBWM_ASSERT(a_cnt_nz, clk, arst_n, !out_load || (cnt_q != '0), "result loaded with empty window")
	`RBBWM_ASSERT_NEXT(a_div_runs, clk, arst_n, div_start, div_busy, "divider did not start")

endmodule
